/* design/smg_pkg.sv */
// shared types, register codes and constants of the multisine generator
package smg_pkg;

    localparam int MAX_TONES  = 64;
    localparam int HARM_W     = 15;
    localparam int PER_W      = 28;
    localparam int ACC_W      = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    typedef struct packed {
        logic               cmd;
        logic [63:0]        now_us;
        logic               gyro_fresh;
        logic               vehicle_ready;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
    } item_t;

    typedef struct packed {
        logic signed [20:0] excitation;
        logic [2:0]         status;
    } result_t;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [2:0] ST_SAMPLE      = 3'd0;
    localparam logic [2:0] ST_STARTED     = 3'd1;
    localparam logic [2:0] ST_FINISHED    = 3'd2;
    localparam logic [2:0] ST_GYRO_LOST   = 3'd3;
    localparam logic [2:0] ST_INTERRUPTED = 3'd4;
    localparam logic [2:0] ST_NOT_READY   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HARMONIC  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_MODE  = 3'd5;

    localparam logic [27:0] PERIOD_US_RESET    = 28'd10000000;
    localparam logic [5:0]  PERIOD_COUNT_RESET = 6'd4;
    localparam logic [13:0] AMPLITUDE_RESET    = 14'd6554;
    localparam logic [15:0] PHASE_OFFSET_RESET = 16'd0;
    localparam logic [14:0] MAX_HARMONIC_RESET = 15'd144;
    localparam logic        SPACING_RESET      = 1'b0;

    localparam logic [63:0]        GYRO_TIMEOUT_US = 64'd500000;
    localparam logic signed [15:0] TILT_LIMIT_Q13  = 16'sd6434;
    localparam logic [20:0]        EXC_LIMIT       = 21'd629146;
    localparam logic [16:0]        SIN_A           = 17'd102873;
    localparam logic [16:0]        SIN_B           = 17'd41906;
    localparam logic [16:0]        SIN_C           = 17'd4569;
    localparam logic [15:0]        RECIP10         = 16'd52428;

endpackage

/* design/schroeder_multisine_generator.sv */
// schroeder multisine generator: top level with harmonic table memory and serial divider
// start: builds the harmonic table, then the started result; a vehicle not ready gives the not-ready result
// sample: the elapsed-time modulo, then per tone
//   (one 75-step and one 44-step pass of the bit-serial divider, plus sine and accumulate)
// samples without tone work give a status result or no result; one item is processed at a time
// rst_n clears control state and restores the register defaults; the table is not cleared
module schroeder_multisine_generator #(
    parameter int MAX_TONES = smg_pkg::MAX_TONES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  smg_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output smg_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [smg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [smg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
    localparam int TONE_W = $clog2(MAX_TONES + 1);
    localparam int SK_W   = 2 * ADDR_W;
    localparam int HW     = smg_pkg::HARM_W;
    localparam int PW     = smg_pkg::PER_W;
    localparam int AW     = smg_pkg::ACC_W;
    localparam int XW     = HW + PW;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECIDE = 5'd1;
    localparam logic [4:0] S_B0     = 5'd2;
    localparam logic [4:0] S_B1     = 5'd3;
    localparam logic [4:0] S_BLOOP  = 5'd4;
    localparam logic [4:0] S_BFIN   = 5'd5;
    localparam logic [4:0] S_RMOD   = 5'd6;
    localparam logic [4:0] S_TREAD  = 5'd7;
    localparam logic [4:0] S_TMUL   = 5'd8;
    localparam logic [4:0] S_HDIV   = 5'd9;
    localparam logic [4:0] S_SDIV   = 5'd10;
    localparam logic [4:0] S_SIN0   = 5'd11;
    localparam logic [4:0] S_SIN1   = 5'd12;
    localparam logic [4:0] S_SIN2   = 5'd13;
    localparam logic [4:0] S_SIN3   = 5'd14;
    localparam logic [4:0] S_SIN4   = 5'd15;
    localparam logic [4:0] S_ACC    = 5'd16;
    localparam logic [4:0] S_ROUND  = 5'd17;
    localparam logic [4:0] S_EMIT   = 5'd18;

    // control registers
    logic [4:0]          state_reg, state_next;
    logic                running_reg, running_next;
    logic [TONE_W-1:0]   tone_count_reg, tone_count_next;
    logic [63:0]         start_time_reg, start_time_next;
    logic [63:0]         last_gyro_reg, last_gyro_next;
    logic                out_valid_reg, out_valid_next;
    logic [6:0]          div_cnt_reg, div_cnt_next;
    logic [27:0]         period_us_reg;
    logic [5:0]          period_count_reg;
    logic [13:0]         amplitude_reg;
    logic [15:0]         offset_reg;
    logic [14:0]         max_harm_reg;
    logic                spacing_reg;

    // payload registers
    smg_pkg::item_t      item_reg, item_next;
    smg_pkg::result_t    res_reg, res_next;
    smg_pkg::result_t    out_reg, out_next;
    logic [PW-1:0]       div_rem_reg, div_rem_next;
    logic [63:0]         div_dvd_reg, div_dvd_next;
    logic [31:0]         div_quo_reg, div_quo_next;
    logic [PW-1:0]       div_den_reg, div_den_next;
    logic [ADDR_W-1:0]   k_reg, k_next;
    logic [TONE_W-1:0]   n_reg, n_next;
    logic [HW-1:0]       prev_reg, prev_next;
    logic [HW-1:0]       prev2_reg, prev2_next;
    logic [PW-1:0]       r_reg, r_next;
    logic [31:0]         ph_reg, ph_next;
    logic [15:0]         off_reg, off_next;
    logic [16:0]         x_reg, x_next;
    logic [1:0]          quad_reg, quad_next;
    logic [16:0]         x2_reg, x2_next;
    logic [16:0]         y_reg, y_next;
    logic [17:0]         s_reg, s_next;
    logic signed [AW-1:0] acc_reg, acc_next;

    // harmonic table memory
    logic [HW-1:0]       table_mem [MAX_TONES];
    logic [HW-1:0]       rd_data_reg;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [HW-1:0]       wr_data;

    // derived values
    logic [PW-1:0]       per;
    logic [HW-1:0]       limit;
    logic [63:0]         elapsed;
    logic [63:0]         gyro_age;
    logic [33:0]         run_len;
    logic                tilted;

    logic [15:0]         fib_next;
    logic [18:0]         geo_x;
    logic [34:0]         geo_p;
    logic [15:0]         geo_q0;
    logic [18:0]         geo_rem;
    logic [15:0]         geo_g;
    logic [15:0]         prev_inc;
    logic [15:0]         geo_next;
    logic [15:0]         next_h;
    logic                loop_ok;

    logic [PW:0]         div_t;
    logic [PW:0]         div_sub;
    logic                div_ge;

    logic [XW-1:0]       harm_prod;
    logic [TONE_W-1:0]   k_inc;
    logic [15+TONE_W:0]  off_full;
    logic [ADDR_W-1:0]   k_dec;
    logic [SK_W-1:0]     sk;
    logic [TONE_W:0]     two_n;

    logic [15:0]         x_raw;
    logic [33:0]         x2_full;
    logic [29:0]         p1_full;
    logic [33:0]         p2_full;
    logic [33:0]         p3_full;
    logic signed [14:0]  amp_s;
    logic signed [18:0]  sine_s;
    logic signed [32:0]  term;

    logic                acc_neg;
    logic [AW-1:0]       acc_mag;
    logic [AW-1:0]       acc_rnd;
    logic [AW-17:0]      rnd_mag;
    logic [20:0]         sat_mag;
    logic signed [20:0]  exc_val;

    function automatic logic [ADDR_W-1:0] k_dec_of(input logic [TONE_W-1:0] n);
        logic [TONE_W-1:0] d;
        d = n - TONE_W'(1);
        return d[ADDR_W-1:0];
    endfunction

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign cfg_ready    = 1'b1;

    assign per      = (period_us_reg == '0) ? PW'(1) : period_us_reg;
    assign limit    = (max_harm_reg == '0) ? HW'(1) : max_harm_reg;
    assign elapsed  = item_reg.now_us - start_time_reg;
    assign gyro_age = item_reg.now_us - last_gyro_reg;
    assign run_len  = 34'(per) * 34'(period_count_reg);
    assign tilted   = (item_reg.roll_angle >= smg_pkg::TILT_LIMIT_Q13)
                   || (item_reg.roll_angle <= -smg_pkg::TILT_LIMIT_Q13)
                   || (item_reg.pitch_angle >= smg_pkg::TILT_LIMIT_Q13)
                   || (item_reg.pitch_angle <= -smg_pkg::TILT_LIMIT_Q13);

    // next harmonic candidate
    assign fib_next = 16'(prev_reg) + 16'(prev2_reg);
    assign geo_x    = 19'({prev_reg, 3'b000}) + 19'({prev_reg, 2'b00}) + 19'd5;
    assign geo_p    = 35'(geo_x) * 35'(smg_pkg::RECIP10);
    assign geo_q0   = geo_p[34:19];
    assign geo_rem  = geo_x - 19'(geo_q0) * 19'd10;
    assign geo_g    = (geo_rem >= 19'd10) ? geo_q0 + 16'd1 : geo_q0;
    assign prev_inc = 16'(prev_reg) + 16'd1;
    assign geo_next = (geo_g > prev_inc) ? geo_g : prev_inc;
    assign next_h   = spacing_reg ? geo_next : fib_next;
    assign loop_ok  = (n_reg < TONE_W'(MAX_TONES - 1)) && (next_h <= 16'(limit));

    // restoring divider step
    assign div_t   = {div_rem_reg, div_dvd_reg[63]};
    assign div_ge  = (div_t >= {1'b0, div_den_reg});
    assign div_sub = div_t - {1'b0, div_den_reg};

    // per-tone operands
    assign harm_prod = XW'(rd_data_reg) * XW'(r_reg);
    assign k_inc     = TONE_W'(k_reg) + TONE_W'(1);
    assign off_full  = (16 + TONE_W)'(offset_reg) * (16 + TONE_W)'(k_inc);
    assign k_dec     = k_reg - ADDR_W'(1);
    assign sk        = SK_W'(k_reg) * SK_W'(k_dec);
    assign two_n     = {tone_count_reg, 1'b0};

    // quarter-wave sine polynomial
    assign x_raw   = ph_reg[29:14];
    assign x2_full = 34'(x_reg) * 34'(x_reg);
    assign p1_full = 30'(x2_reg) * 30'(smg_pkg::SIN_C);
    assign p2_full = 34'(x2_reg) * 34'(y_reg);
    assign p3_full = 34'(x_reg) * 34'(y_reg);
    assign amp_s   = $signed({1'b0, amplitude_reg});
    assign sine_s  = quad_reg[1] ? -$signed({1'b0, s_reg}) : $signed({1'b0, s_reg});
    assign term    = 33'(amp_s) * 33'(sine_s);

    // round half away from zero and saturate
    assign acc_neg = acc_reg[AW-1];
    assign acc_mag = acc_neg ? AW'(-acc_reg) : AW'(acc_reg);
    assign acc_rnd = acc_mag + AW'(32768);
    assign rnd_mag = acc_rnd[AW-1:16];
    assign sat_mag = (rnd_mag > (AW-16)'(smg_pkg::EXC_LIMIT)) ? smg_pkg::EXC_LIMIT
                                                              : rnd_mag[20:0];
    assign exc_val = acc_neg ? -$signed(sat_mag) : $signed(sat_mag);

    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        tone_count_next = tone_count_reg;
        start_time_next = start_time_reg;
        last_gyro_next  = last_gyro_reg;
        out_valid_next  = out_valid_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        prev_next       = prev_reg;
        prev2_next      = prev2_reg;
        r_next          = r_reg;
        ph_next         = ph_reg;
        off_next        = off_reg;
        x_next          = x_reg;
        quad_next       = quad_reg;
        x2_next         = x2_reg;
        y_next          = y_reg;
        s_next          = s_reg;
        acc_next        = acc_reg;
        wr_en           = 1'b0;
        wr_addr         = n_reg[ADDR_W-1:0];
        wr_data         = prev_reg;

        div_rem_next = div_rem_reg;
        div_dvd_next = div_dvd_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;
        div_cnt_next = div_cnt_reg;
        if (div_cnt_reg != '0)
        begin
            div_rem_next = div_ge ? div_sub[PW-1:0] : div_t[PW-1:0];
            div_dvd_next = {div_dvd_reg[62:0], 1'b0};
            div_quo_next = {div_quo_reg[30:0], div_ge};
            div_cnt_next = div_cnt_reg - 7'd1;
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                res_next.excitation = '0;
                if (item_reg.cmd == smg_pkg::CMD_START)
                begin
                    if (!item_reg.vehicle_ready)
                    begin
                        running_next    = 1'b0;
                        res_next.status = smg_pkg::ST_NOT_READY;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        start_time_next = item_reg.now_us;
                        last_gyro_next  = item_reg.now_us;
                        state_next      = S_B0;
                    end
                end
                else if (!running_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (elapsed >= 64'(run_len))
                begin
                    running_next    = 1'b0;
                    res_next.status = smg_pkg::ST_FINISHED;
                    state_next      = S_EMIT;
                end
                else if (!item_reg.gyro_fresh)
                begin
                    if (gyro_age > smg_pkg::GYRO_TIMEOUT_US)
                    begin
                        running_next    = 1'b0;
                        res_next.status = smg_pkg::ST_GYRO_LOST;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    last_gyro_next = item_reg.now_us;
                    if (!item_reg.vehicle_ready || tilted)
                    begin
                        running_next    = 1'b0;
                        res_next.status = smg_pkg::ST_INTERRUPTED;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        div_rem_next = '0;
                        div_dvd_next = elapsed;
                        div_quo_next = '0;
                        div_den_next = per;
                        div_cnt_next = 7'd64;
                        state_next   = S_RMOD;
                    end
                end
            end
            S_B0:
            begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = HW'(1);
                prev_next = HW'(1);
                n_next    = TONE_W'(1);
                state_next = (limit >= HW'(2)) ? S_B1 : S_BFIN;
            end
            S_B1:
            begin
                wr_en      = 1'b1;
                wr_addr    = ADDR_W'(1);
                wr_data    = HW'(2);
                prev2_next = HW'(1);
                prev_next  = HW'(2);
                n_next     = TONE_W'(2);
                state_next = S_BLOOP;
            end
            S_BLOOP:
            begin
                if (loop_ok)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = n_reg[ADDR_W-1:0];
                    wr_data    = next_h[HW-1:0];
                    prev2_next = prev_reg;
                    prev_next  = next_h[HW-1:0];
                    n_next     = n_reg + TONE_W'(1);
                end
                else
                begin
                    state_next = S_BFIN;
                end
            end
            S_BFIN:
            begin
                tone_count_next = n_reg;
                running_next    = 1'b1;
                if (prev_reg < limit)
                begin
                    wr_en   = 1'b1;
                    wr_data = limit;
                    if (n_reg < TONE_W'(MAX_TONES))
                    begin
                        wr_addr         = n_reg[ADDR_W-1:0];
                        tone_count_next = n_reg + TONE_W'(1);
                    end
                    else
                    begin
                        wr_addr = k_dec_of(n_reg);
                    end
                end
                res_next.status = smg_pkg::ST_STARTED;
                state_next      = S_EMIT;
            end
            S_RMOD:
            begin
                if (div_cnt_reg == '0)
                begin
                    r_next     = div_rem_reg;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = S_TREAD;
                end
            end
            S_TREAD:
            begin
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                off_next     = off_full[15:0];
                div_rem_next = '0;
                div_dvd_next = {harm_prod, {(64 - XW){1'b0}}};
                div_quo_next = '0;
                div_den_next = per;
                div_cnt_next = 7'(XW + 32);
                state_next   = S_HDIV;
            end
            S_HDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    ph_next      = div_quo_reg;
                    div_rem_next = '0;
                    div_dvd_next = {sk, {(64 - SK_W){1'b0}}};
                    div_quo_next = '0;
                    div_den_next = PW'(two_n);
                    div_cnt_next = 7'(SK_W + 32);
                    state_next   = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    ph_next    = ph_reg + div_quo_reg + {off_reg, 16'h0000};
                    state_next = S_SIN0;
                end
            end
            S_SIN0:
            begin
                quad_next  = ph_reg[31:30];
                x_next     = ph_reg[30] ? 17'd65536 - 17'(x_raw) : 17'(x_raw);
                state_next = S_SIN1;
            end
            S_SIN1:
            begin
                x2_next    = x2_full[32:16];
                state_next = S_SIN2;
            end
            S_SIN2:
            begin
                y_next     = smg_pkg::SIN_B - 17'(p1_full[29:16]);
                state_next = S_SIN3;
            end
            S_SIN3:
            begin
                y_next     = smg_pkg::SIN_A - p2_full[32:16];
                state_next = S_SIN4;
            end
            S_SIN4:
            begin
                s_next     = p3_full[33:16];
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg + AW'(term);
                if (k_inc == tone_count_reg)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = S_TREAD;
                end
            end
            S_ROUND:
            begin
                res_next.excitation = exc_val;
                res_next.status     = smg_pkg::ST_SAMPLE;
                state_next          = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            running_reg      <= 1'b0;
            tone_count_reg   <= '0;
            start_time_reg   <= '0;
            last_gyro_reg    <= '0;
            out_valid_reg    <= 1'b0;
            div_cnt_reg      <= '0;
            period_us_reg    <= smg_pkg::PERIOD_US_RESET;
            period_count_reg <= smg_pkg::PERIOD_COUNT_RESET;
            amplitude_reg    <= smg_pkg::AMPLITUDE_RESET;
            offset_reg       <= smg_pkg::PHASE_OFFSET_RESET;
            max_harm_reg     <= smg_pkg::MAX_HARMONIC_RESET;
            spacing_reg      <= smg_pkg::SPACING_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            tone_count_reg <= tone_count_next;
            start_time_reg <= start_time_next;
            last_gyro_reg  <= last_gyro_next;
            out_valid_reg  <= out_valid_next;
            div_cnt_reg    <= div_cnt_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    smg_pkg::REG_PERIOD_US:    period_us_reg    <= cfg_data[27:0];
                    smg_pkg::REG_PERIOD_COUNT: period_count_reg <= cfg_data[5:0];
                    smg_pkg::REG_AMPLITUDE:    amplitude_reg    <= cfg_data[13:0];
                    smg_pkg::REG_PHASE_OFFSET: offset_reg       <= cfg_data[15:0];
                    smg_pkg::REG_MAX_HARMONIC: max_harm_reg     <= cfg_data[14:0];
                    smg_pkg::REG_SPACING_MODE: spacing_reg      <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        div_rem_reg <= div_rem_next;
        div_dvd_reg <= div_dvd_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        k_reg       <= k_next;
        n_reg       <= n_next;
        prev_reg    <= prev_next;
        prev2_reg   <= prev2_next;
        r_reg       <= r_next;
        ph_reg      <= ph_next;
        off_reg     <= off_next;
        x_reg       <= x_next;
        quad_reg    <= quad_next;
        x2_reg      <= x2_next;
        y_reg       <= y_next;
        s_reg       <= s_next;
        acc_reg     <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[k_reg];
    end

`ifndef NO_ASSERTIONS
    a_exc_zero_off_sample: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != smg_pkg::ST_SAMPLE) |-> result.excitation == '0)
        else $error("nonzero excitation on a status result");

    a_exc_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.excitation <= $signed(smg_pkg::EXC_LIMIT))
                      && (result.excitation >= -$signed(smg_pkg::EXC_LIMIT)))
        else $error("excitation outside saturation range");

    a_tone_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (tone_count_reg != '0) && (tone_count_reg <= TONE_W'(MAX_TONES)))
        else $error("tone count out of range while running");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && !(out_valid_reg && result_stall) |=> result_valid)
        else $error("pending request not moved to output");
`endif

endmodule
